>>> src/scrr_pkg.sv
// Package for the S-curve reference ramp: payload structs, constants, FSM states.
// No dependencies.
package scrr_pkg;

  localparam int RefFracBits  = 23;
  localparam int StepFracBits = 40;
  localparam int StepShift    = StepFracBits - RefFracBits;
  localparam int CountLimit   = 300000;
  localparam int CountPark    = 400000;

  localparam logic [47:0] StepMax  = 48'h7FFF_FFFF_FFFF;
  localparam logic [23:0] StopSnap = 24'd4194;

  localparam logic [1:0] CfgAccel  = 2'd0;
  localparam logic [1:0] CfgDecel  = 2'd1;
  localparam logic [1:0] CfgScurve = 2'd2;
  localparam logic [1:0] CfgWeight = 2'd3;

  typedef struct packed {
    logic signed [23:0] target_reference;
    logic               drive_on;
    logic               stop_request;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] output_reference;
    logic               accelerating;
    logic               decelerating;
    logic               reverse_direction;
  } out_item_t;

  // Divider request: floor(num / den), 64-bit unsigned.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV_A,
    ST_MUL_A,
    ST_DIV_AR,
    ST_DIV_D,
    ST_MUL_D,
    ST_DIV_DR,
    ST_SHAPE,
    ST_SHAPE_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

endpackage

>>> src/scrr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on scrr_pkg.
module scrr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  scrr_pkg::div_req_t req,
  output scrr_pkg::div_rsp_t rsp
);
  import scrr_pkg::*;

  logic [63:0] quot_r, quot_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[63:0], quot_r[63]};
    diff     = shifted - {1'b0, den_r};
    if (req.start) begin
      quot_nxt = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract if it fits
      if (!diff[64]) begin
        rem_nxt  = diff;
        quot_nxt = {quot_r[62:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        quot_nxt = {quot_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r[63:0];
endmodule

>>> src/s_curve_reference_ramp_core.sv
// S-curve reference ramp: sequencer, state and output register around one
// shared serial divider. Depends on scrr_pkg and scrr_div.
// An unchanged target takes the linear path, or one division when S-curve shaping
// needs it; a target change adds four divisions. One item at a time: in_ready returns
// in the same cycle that out_valid rises, and a result still waiting in the output
// register holds the sequencer.
// Reset (synchronous, rst_n low) clears all ramp state and loads register defaults.
module s_curve_reference_ramp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scrr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scrr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_wdata
);
  import scrr_pkg::*;

  state_t state_r, state_nxt;

  logic [23:0] accel_ticks_r, decel_ticks_r;
  logic        s_curve_r;
  logic [9:0]  weight_r;

  logic signed [23:0] prev_tgt_r, prev_tgt_nxt;
  logic signed [23:0] cur_ref_r, cur_ref_nxt;
  logic signed [47:0] accel_step_r, accel_step_nxt, decel_step_r, decel_step_nxt;
  logic signed [24:0] accel_span_r, accel_span_nxt, decel_span_r, decel_span_nxt;
  logic signed [47:0] accel_peak_r, accel_peak_nxt, decel_peak_r, decel_peak_nxt;
  logic [18:0] tick_r, tick_nxt;
  logic        rev_r, rev_nxt, done_flag_r, done_flag_nxt;

  logic signed [23:0] set_r, set_nxt;
  logic        stop_r, stop_nxt;
  logic [47:0] q_r, q_nxt;     // quotient magnitude stash
  logic [63:0] scale_r, scale_nxt; // multiplier m for current division
  logic        shape_do_r, shape_do_nxt; // division in flight on the shared divider
  logic        shape_add_r, shape_add_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  scrr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // live register views
  logic [23:0] at, dt;
  logic [9:0]  pm;
  logic [10:0] pm_c;
  assign at   = (accel_ticks_r == '0) ? 24'd1 : accel_ticks_r;
  assign dt   = (decel_ticks_r == '0) ? 24'd1 : decel_ticks_r;
  assign pm   = (weight_r > 10'd1000) ? 10'd1000 : weight_r;
  assign pm_c = 11'd2000 - {1'b0, pm};

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    mag48 = v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic [24:0] mag25(input logic signed [24:0] v);
    mag25 = v[24] ? 25'(-v) : 25'(v);
  endfunction

  function automatic logic signed [47:0] sat_sign(input logic [63:0] m, input logic neg);
    logic [47:0] r;
    r = (m > {16'd0, StepMax}) ? StepMax : m[47:0];
    sat_sign = neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [47:0] clamp49(input logic signed [48:0] v);
    if (v > $signed({1'b0, StepMax})) clamp49 = $signed(StepMax);
    else if (v < -$signed({1'b0, StepMax})) clamp49 = -$signed(StepMax);
    else clamp49 = v[47:0];
  endfunction

  function automatic logic signed [24:0] step_ref(input logic signed [47:0] s);
    logic [47:0] m;
    logic [47:0] r;
    m = mag48(s) + (48'd1 << (StepShift - 1));
    r = m >> StepShift;
    step_ref = s[47] ? -$signed(r[24:0]) : $signed(r[24:0]);
  endfunction

  // selected span / ticks / peak for division stages
  logic signed [24:0] span_sel;
  logic [23:0] ticks_sel;
  logic        use_dec;
  logic [63:0] prod_tw;   // ticks * (2000-pm) with S-curve, else ticks
  logic [35:0] t2000;
  logic [33:0] tk_pm;
  logic [34:0] tk_cpm;
  logic signed [47:0] peak_sel, step_sel;

  always_comb begin
    use_dec   = (state_r == ST_DIV_D) || (state_r == ST_MUL_D) || (state_r == ST_DIV_DR);
    span_sel  = use_dec ? decel_span_r : accel_span_r;
    ticks_sel = use_dec ? dt : at;
    prod_tw   = s_curve_r ? 64'(35'(ticks_sel) * 35'(pm_c)) : 64'(ticks_sel);
    t2000     = 36'(tick_r) * 36'd2000;
    // shaping chooses decel when its span is nonzero
    tk_pm     = (decel_span_r != '0) ? 34'(dt) * 34'(pm) : 34'(at) * 34'(pm);
    tk_cpm    = (decel_span_r != '0) ? 35'(dt) * 35'(pm_c) : 35'(at) * 35'(pm_c);
    peak_sel  = (decel_span_r != '0) ? decel_peak_r : accel_peak_r;
    step_sel  = (decel_span_r != '0) ? decel_step_r : accel_step_r;
  end

  logic signed [24:0] diff;
  logic [24:0] adiff, aset, aref;
  logic opp;
  assign aset  = mag25(25'(set_r));
  assign aref  = mag25(25'(cur_ref_r));
  assign diff  = 25'(set_r) - 25'(cur_ref_r);
  assign adiff = mag25(diff);
  assign opp   = (set_r < 0 && cur_ref_r > 0) || (set_r > 0 && cur_ref_r < 0);

  logic signed [25:0] ref_w;
  logic acc_f, dec_f;
  logic [47:0] dsh, ash;

  always_comb begin
    state_nxt      = state_r;
    prev_tgt_nxt   = prev_tgt_r;
    cur_ref_nxt    = cur_ref_r;
    accel_step_nxt = accel_step_r;
    decel_step_nxt = decel_step_r;
    accel_span_nxt = accel_span_r;
    decel_span_nxt = decel_span_r;
    accel_peak_nxt = accel_peak_r;
    decel_peak_nxt = decel_peak_r;
    tick_nxt       = tick_r;
    rev_nxt        = rev_r;
    done_flag_nxt  = done_flag_r;
    set_nxt        = set_r;
    stop_nxt       = stop_r;
    q_nxt          = q_r;
    scale_nxt      = scale_r;
    shape_do_nxt   = shape_do_r;
    shape_add_nxt  = shape_add_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    dreq           = '0;
    ref_w          = '0;
    acc_f          = 1'b0;
    dec_f          = 1'b0;
    dsh            = '0;
    ash            = '0;
    in_ready       = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          stop_nxt = in_data.stop_request;
          set_nxt  = (!in_data.drive_on || in_data.stop_request) ? '0
                                                                 : in_data.target_reference;
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (set_r != prev_tgt_r) begin
          if (opp) begin
            accel_span_nxt = 25'(set_r);
            decel_span_nxt = 25'(cur_ref_r);
            rev_nxt = 1'b1;
          end else if (aset > aref) begin
            accel_span_nxt = diff;
            decel_span_nxt = '0;
          end else if (aset < aref) begin
            accel_span_nxt = '0;
            decel_span_nxt = -diff;
          end else begin
            accel_span_nxt = '0;
            decel_span_nxt = '0;
          end
          tick_nxt  = '0;
          state_nxt = ST_DIV_A;
        end else begin
          state_nxt = ST_SHAPE;
        end
        prev_tgt_nxt = set_r;
      end
      // q = (|span| << shift) / d ; result = q*m + (r*m)/d
      ST_DIV_A, ST_DIV_D: begin
        if (!shape_do_r) begin
          dreq.start   = 1'b1;
          dreq.num     = 64'(mag25(span_sel)) << StepShift;
          dreq.den     = prod_tw;
          shape_do_nxt = 1'b1;
          scale_nxt    = s_curve_r ? 64'd2000 : 64'd1;
        end else if (drsp.done) begin
          shape_do_nxt = 1'b0;
          q_nxt        = drsp.quot[47:0];
          state_nxt    = (state_r == ST_DIV_A) ? ST_MUL_A : ST_MUL_D;
          dreq.start   = 1'b1;
          dreq.num     = 64'(drsp.rem[34:0]) * 64'(scale_r[10:0]);
          dreq.den     = prod_tw;
        end
      end
      ST_MUL_A, ST_MUL_D: begin
        // register q*m while the remainder division runs
        q_nxt     = q_r * 48'(scale_r[10:0]);
        state_nxt = (state_r == ST_MUL_A) ? ST_DIV_AR : ST_DIV_DR;
      end
      ST_DIV_AR, ST_DIV_DR: begin
        if (drsp.done) begin
          if (state_r == ST_DIV_AR) begin
            if (s_curve_r) begin
              accel_peak_nxt = sat_sign(64'(q_r) + drsp.quot, span_sel[24]);
              accel_step_nxt = (pm == '0) ? accel_peak_nxt : '0;
            end else begin
              accel_step_nxt = sat_sign(64'(q_r) + drsp.quot, span_sel[24]);
            end
            state_nxt = ST_DIV_D;
          end else begin
            if (s_curve_r) begin
              decel_peak_nxt = sat_sign(64'(q_r) + drsp.quot, span_sel[24]);
              decel_step_nxt = (pm == '0) ? decel_peak_nxt : '0;
            end else begin
              decel_step_nxt = sat_sign(64'(q_r) + drsp.quot, span_sel[24]);
            end
            state_nxt = ST_SHAPE;
          end
        end
      end
      ST_SHAPE: begin
        tick_nxt = (19'(tick_r + 19'd1) >= 19'(CountLimit)) ? 19'(CountPark)
                                                             : 19'(tick_r + 19'd1);
        state_nxt = ST_APPLY;
        if (s_curve_r && (decel_span_r != '0 || accel_span_r != '0)) begin
          state_nxt = ST_SHAPE_DIV;
        end
      end
      ST_SHAPE_DIV: begin
        if (!shape_do_r) begin
          if ({5'd0, tick_r} > ((decel_span_r != '0) ? dt : at)) begin
            if (decel_span_r != '0) begin
              decel_step_nxt = '0;
              if (rev_r) begin
                decel_span_nxt = '0;
                tick_nxt = '0;
              end else begin
                done_flag_nxt = 1'b1;
              end
            end else begin
              accel_step_nxt = '0;
              done_flag_nxt  = 1'b1;
            end
            state_nxt = ST_APPLY;
          end else if (t2000 < 36'(tk_pm) ||
                       t2000 > 36'(tk_cpm)) begin
            shape_add_nxt = t2000 < 36'(tk_pm);
            shape_do_nxt  = 1'b1;
            dreq.start    = 1'b1;
            dreq.num      = 64'(mag48(peak_sel)) * 64'd2000;
            dreq.den      = (tk_pm == '0) ? 64'd1 : 64'(tk_pm);
          end else begin
            state_nxt = ST_APPLY;
          end
        end else if (drsp.done) begin
          shape_do_nxt = 1'b0;
          if (decel_span_r != '0) begin
            decel_step_nxt = clamp49(49'(step_sel) + (shape_add_r ? 49'(sat_sign(drsp.quot, peak_sel[47]))
                                                                  : -49'(sat_sign(drsp.quot, peak_sel[47]))));
          end else begin
            accel_step_nxt = clamp49(49'(step_sel) + (shape_add_r ? 49'(sat_sign(drsp.quot, peak_sel[47]))
                                                                  : -49'(sat_sign(drsp.quot, peak_sel[47]))));
          end
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold until the previous item has left the output register
        if (!out_valid_r || out_ready) begin
          ref_w = 26'(cur_ref_r);
          dsh = mag48(decel_step_r) >> StepShift;
          ash = mag48(accel_step_r) >> StepShift;
          if (48'(adiff) <= dsh || 48'(adiff) <= ash || done_flag_r) begin
            ref_w = 26'(set_r);
            done_flag_nxt = 1'b0;
            rev_nxt = 1'b0;
          end else if (opp) begin
            ref_w = 26'(cur_ref_r) - 26'(step_ref(decel_step_r));
            dec_f = 1'b1;
          end else if (aset > aref) begin
            ref_w = 26'(cur_ref_r) + 26'(step_ref(accel_step_r));
            acc_f = 1'b1;
          end else if (aset < aref) begin
            ref_w = 26'(cur_ref_r) - 26'(step_ref(decel_step_r));
            dec_f = 1'b1;
          end else begin
            ref_w = 26'(set_r);
            accel_step_nxt = '0;
            decel_step_nxt = '0;
            rev_nxt = 1'b0;
          end
          if (aref <= 25'(StopSnap) && stop_r) begin
            ref_w = '0;
            accel_step_nxt = '0;
            decel_step_nxt = '0;
            rev_nxt = 1'b0;
            done_flag_nxt = 1'b0;
          end
          if (ref_w > 26'sd8388607) ref_w = 26'sd8388607;
          if (ref_w < -26'sd8388608) ref_w = -26'sd8388608;
          cur_ref_nxt = ref_w[23:0];
          out_nxt.output_reference  = ref_w[23:0];
          out_nxt.accelerating      = acc_f;
          out_nxt.decelerating      = dec_f;
          out_nxt.reverse_direction = ref_w[25];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // output register is free here; raise valid for the new item
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      accel_ticks_r <= 24'd10000;
      decel_ticks_r <= 24'd10000;
      s_curve_r     <= 1'b0;
      weight_r      <= '0;
      prev_tgt_r    <= '0;
      cur_ref_r     <= '0;
      accel_step_r  <= '0;
      decel_step_r  <= '0;
      accel_span_r  <= '0;
      decel_span_r  <= '0;
      accel_peak_r  <= '0;
      decel_peak_r  <= '0;
      tick_r        <= '0;
      rev_r         <= 1'b0;
      done_flag_r   <= 1'b0;
      shape_do_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_tgt_r   <= prev_tgt_nxt;
      cur_ref_r    <= cur_ref_nxt;
      accel_step_r <= accel_step_nxt;
      decel_step_r <= decel_step_nxt;
      accel_span_r <= accel_span_nxt;
      decel_span_r <= decel_span_nxt;
      accel_peak_r <= accel_peak_nxt;
      decel_peak_r <= decel_peak_nxt;
      tick_r       <= tick_nxt;
      rev_r        <= rev_nxt;
      done_flag_r  <= done_flag_nxt;
      shape_do_r   <= shape_do_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CfgAccel:  accel_ticks_r <= cfg_wdata;
          CfgDecel:  decel_ticks_r <= cfg_wdata;
          CfgScurve: s_curve_r     <= cfg_wdata[0];
          CfgWeight: weight_r      <= cfg_wdata[9:0];
          default:   ;
        endcase
      end
    end
    set_r       <= set_nxt;
    stop_r      <= stop_nxt;
    q_r         <= q_nxt;
    scale_r     <= scale_nxt;
    shape_add_r <= shape_add_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

>>> bench/s_curve_reference_ramp_core_test.sv
// Self-checking bench for s_curve_reference_ramp_core: queue-fed driver, clocked monitor
// and a cycle-free ramp predictor. Depends on scrr_pkg and the core RTL.
`timescale 1ns / 100ps

module s_curve_reference_ramp_core_test;
  import scrr_pkg::*;

  localparam int WatchLimit = 20000;
  localparam longint RefOne = longint'(1) << RefFracBits;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CfgAccel;
  logic [23:0] cfg_wdata = '0;

  s_curve_reference_ramp_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  in_item_t pending_items[$];
  out_item_t ramp_expected[$];
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_count = 0;
  bit hold_asked = 0;
  bit hold_taken = 0;
  int idle_cycles = 0;

  // ramp predictor state and registers
  int unsigned r_accel_ticks, r_decel_ticks, r_scurve, r_weight;
  longint prev_tgt, ramp_ref, acc_step, dec_step, acc_span, dec_span, acc_peak, dec_peak;
  int unsigned ramp_ticks;
  bit reversing, shaped_out;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp_step(longint v);
    longint smax;
    smax = longint'(StepMax);
    if (v > smax) return smax;
    if (v < -smax) return -smax;
    return v;
  endfunction

  // sign(v) * floor(|v| * 2^sh * m / d), held within the step limit
  function automatic longint scaled_div(longint v, int sh, longint unsigned m,
                                        longint unsigned d);
    longint unsigned a, q, r, res;
    a = mag(v) << sh;
    if (d == 0) d = 1;
    q = a / d;
    r = a % d;
    res = q * m + (r * m) / d;
    if (res > longint'(StepMax)) res = longint'(StepMax);
    return v < 0 ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint step_to_ref(longint s);
    longint unsigned r;
    r = (mag(s) + (longint'(1) << (StepShift - 1))) >> StepShift;
    return s < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit shape_step(inout longint s, input longint peak,
                                    input longint unsigned ticks, input longint unsigned pm);
    longint unsigned t2000;
    t2000 = longint'(ramp_ticks) * 2000;
    if (longint'(ramp_ticks) > ticks) begin
      s = 0;
      return 1'b1;
    end
    if (t2000 < ticks * pm)
      s = clamp_step(s + scaled_div(peak, 0, 2000, ticks * pm));
    else if (t2000 > ticks * (2000 - pm))
      s = clamp_step(s - scaled_div(peak, 0, 2000, ticks * pm));
    return 1'b0;
  endfunction

  function automatic void ramp_reset();
    r_accel_ticks = 10000;
    r_decel_ticks = 10000;
    r_scurve = 0;
    r_weight = 0;
    prev_tgt = 0; ramp_ref = 0;
    acc_step = 0; dec_step = 0; acc_span = 0; dec_span = 0;
    acc_peak = 0; dec_peak = 0;
    ramp_ticks = 0; reversing = 0; shaped_out = 0;
  endfunction

  function automatic out_item_t ramp_predict(in_item_t x);
    longint tgt, r;
    longint unsigned at, dt, pm, atgt, aref, adiff;
    bit opp, sc, acc, dec;
    out_item_t o;
    tgt = longint'($signed(x.target_reference));
    r = ramp_ref;
    sc = r_scurve != 0;
    at = r_accel_ticks != 0 ? r_accel_ticks : 1;
    dt = r_decel_ticks != 0 ? r_decel_ticks : 1;
    pm = r_weight > 1000 ? 1000 : r_weight;
    acc = 0;
    dec = 0;
    if (!x.drive_on || x.stop_request) tgt = 0;
    atgt = mag(tgt);
    aref = mag(r);
    opp = (tgt < 0 && r > 0) || (tgt > 0 && r < 0);

    if (tgt != prev_tgt) begin
      if (opp) begin
        acc_span = tgt; dec_span = r; reversing = 1;
      end else if (atgt > aref) begin
        acc_span = tgt - r; dec_span = 0;
      end else if (atgt < aref) begin
        acc_span = 0; dec_span = r - tgt;
      end else begin
        acc_span = 0; dec_span = 0;
      end
      if (sc) begin
        acc_peak = scaled_div(acc_span, StepShift, 2000, at * (2000 - pm));
        dec_peak = scaled_div(dec_span, StepShift, 2000, dt * (2000 - pm));
        acc_step = pm == 0 ? acc_peak : 0;
        dec_step = pm == 0 ? dec_peak : 0;
      end else begin
        acc_step = scaled_div(acc_span, StepShift, 1, at);
        dec_step = scaled_div(dec_span, StepShift, 1, dt);
      end
      ramp_ticks = 0;
    end
    prev_tgt = tgt;
    ramp_ticks++;
    if (ramp_ticks >= CountLimit) ramp_ticks = CountPark;

    if (sc) begin
      if (dec_span != 0) begin
        if (shape_step(dec_step, dec_peak, dt, pm)) begin
          if (reversing) begin
            dec_span = 0; ramp_ticks = 0;
          end else shaped_out = 1;
        end
      end else if (acc_span != 0) begin
        if (shape_step(acc_step, acc_peak, at, pm)) shaped_out = 1;
      end
    end

    adiff = mag(tgt - r);
    if (adiff <= (mag(dec_step) >> StepShift) || adiff <= (mag(acc_step) >> StepShift) ||
        shaped_out) begin
      r = tgt; shaped_out = 0; reversing = 0;
    end else if (opp) begin
      r -= step_to_ref(dec_step); dec = 1;
    end else if (atgt > aref) begin
      r += step_to_ref(acc_step); acc = 1;
    end else if (atgt < aref) begin
      r -= step_to_ref(dec_step); dec = 1;
    end else begin
      r = tgt; acc_step = 0; dec_step = 0; reversing = 0;
    end

    // snap to zero on a stop near zero
    if (aref <= longint'(StopSnap) && x.stop_request) begin
      r = 0; acc_step = 0; dec_step = 0; reversing = 0; shaped_out = 0;
    end

    if (r > RefOne) r = RefOne;
    if (r < -RefOne) r = -RefOne;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    ramp_ref = r;
    o.output_reference = r[23:0];
    o.accelerating = acc;
    o.decelerating = dec;
    o.reverse_direction = r < 0;
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // sender: hold each item until accepted, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) ramp_expected.push_back(ramp_predict(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ramp_expected.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errors++;
        end else begin
          want = ramp_expected.pop_front();
          if (out_data.output_reference !== want.output_reference ||
              out_data.accelerating !== want.accelerating ||
              out_data.decelerating !== want.decelerating ||
              out_data.reverse_direction !== want.reverse_direction) begin
            $display("%0t: mismatch expected ref=%0d acc=%b dec=%b rev=%b", $realtime,
                     want.output_reference, want.accelerating, want.decelerating,
                     want.reverse_direction);
            $display("%0t:          actual   ref=%0d acc=%b dec=%b rev=%b", $realtime,
                     out_data.output_reference, out_data.accelerating,
                     out_data.decelerating, out_data.reverse_direction);
            errors++;
          end
        end
      end
      if (hold_count > 0) begin
        hold_count <= hold_count - 1;
        out_ready <= 1'b0;
      end else if (hold_asked && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_count <= 1200;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CfgAccel: r_accel_ticks = val;
      CfgDecel: r_decel_ticks = val;
      CfgScurve: r_scurve = val[0];
      default: r_weight = val[9:0];
    endcase
  endtask

  task automatic set_regs(int unsigned a, int unsigned d, int unsigned s, int unsigned w);
    write_reg(CfgAccel, 24'(a));
    write_reg(CfgDecel, 24'(d));
    write_reg(CfgScurve, 24'(s));
    write_reg(CfgWeight, 24'(w));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || ramp_expected.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_item(logic signed [23:0] t, logic on, logic stp);
    in_item_t x;
    x.target_reference = t;
    x.drive_on = on;
    x.stop_request = stp;
    pending_items.push_back(x);
  endtask

  function automatic logic signed [23:0] pick_target();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 24'($urandom());
    if (p < 65) return $signed(24'($urandom_range(20000))) - 24'sd10000;
    if (p < 75) return p[0] ? 24'sh7FFFFF : 24'sh800000;
    if (p < 85) return p[0] ? 24'sh400000 : -24'sh400000;
    return $signed(24'($urandom_range(8000))) - 24'sd4000;
  endfunction

  // one held target with random length; some runs are noise
  task automatic add_run();
    logic signed [23:0] t;
    int len, p;
    logic on, stp;
    t = pick_target();
    len = $urandom_range(30, 1);
    p = $urandom_range(99);
    on = p >= 8;
    stp = p >= 8 && p < 20;
    for (int k = 0; k < len; k++) begin
      if (p >= 90) add_item(24'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else add_item(t, on, stp);
    end
  endtask

  task automatic run_random(int count);
    int goal;
    goal = pending_items.size() + count;
    while (pending_items.size() < goal) add_run();
  endtask

  initial begin
    ramp_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, then fast ramps through the special cases
    add_item(24'sh7FFFFF, 1'b1, 1'b0);
    add_item(24'sh800000, 1'b1, 1'b0);
    add_item(24'sh000000, 1'b1, 1'b0);
    add_item(24'sh123456, 1'b0, 1'b0);
    add_item(24'sh000010, 1'b1, 1'b1);
    wait_drained();
    set_regs(0, 1, 0, 0);
    add_item(24'sh7FFFFF, 1'b1, 1'b0);
    add_item(24'sh7FFFFF, 1'b1, 1'b0);
    add_item(24'sh800000, 1'b1, 1'b0);
    add_item(24'sh800000, 1'b1, 1'b0);
    add_item(24'sh800000, 1'b1, 1'b0);
    add_item(24'sh000800, 1'b1, 1'b0);
    add_item(24'sh000800, 1'b1, 1'b1);
    add_item(24'sh000800, 1'b1, 1'b1);
    add_item(-24'sh000200, 1'b1, 1'b0);
    add_item(24'sh000000, 1'b0, 1'b1);
    wait_drained();
    set_regs(4, 6, 1, 1023);
    for (int k = 0; k < 10; k++) add_item(k < 5 ? 24'sh600000 : -24'sh600000, 1'b1, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    set_regs(3, 3, 0, 0);
    hold_asked = 1;
    run_random(120);
    wait_drained();

    set_regs(1, 16777215, 0, 0);
    run_random(60);
    wait_drained();
    set_regs(20, 30, 1, 0);
    run_random(100);
    wait_drained();
    set_regs(40, 25, 1, 500);
    run_random(100);
    wait_drained();
    set_regs(12, 16, 1, 1000);
    run_random(100);
    wait_drained();
    set_regs(16777215, 2, 1, 250);
    run_random(60);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      set_regs($urandom_range(64), $urandom_range(64), $urandom_range(1), $urandom_range(1023));
      run_random(90);
      wait_drained();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
